@@ sv/hcbp_pkg.sv @@
// Shared types and constants for the Huffman code bit packer.
// Used by the front end, the queue, the back end and the top level.
package hcbp_pkg;

    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int PEND_W  = 7;
    localparam int CNT_W   = 3;
    localparam int WORK_W  = 64;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0] value;
        logic [LEN_W-1:0]  len;
    } code_entry_t;

    typedef struct packed {
        logic        is_flush;
        code_entry_t code;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ sv/hcbp_front.sv @@
// Front end: accepts input transfers, owns the code table and classifies items.
// Depends on hcbp_pkg; feeds jobs into hcbp_queue.
module hcbp_front
    import hcbp_pkg::*;
#(
    parameter int SYMBOLS      = 256,
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [7:0]        symbol,
    input  logic [CODE_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_len,
    input  q_status_t         q_status,
    output logic              push,
    output job_t              push_job
);

    localparam int IDX_W = $clog2(SYMBOLS);

    code_entry_t       mem [SYMBOLS];
    code_entry_t       rdata_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_flush_reg;
    logic              s1_flush_next;
    logic              accept;
    logic              advance;
    logic              in_range;
    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  idx;
    code_entry_t       wr_entry;

    assign in_stall = s1_valid_reg && q_status.full;
    assign advance  = !in_stall;
    assign accept   = in_valid && !in_stall;
    assign idx      = symbol[IDX_W-1:0];
    assign in_range = ({1'b0, symbol} < 9'(SYMBOLS));

    assign wr_en = accept && (req_type == REQ_LOAD) && in_range
                   && (code_len <= LEN_W'(MAX_CODE_LEN));
    assign rd_en = accept && (req_type == REQ_ENCODE) && in_range;

    assign wr_entry.value = code_bits & ~({CODE_W{1'b1}} << code_len);
    assign wr_entry.len   = code_len;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[idx];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_flush_next = s1_flush_reg;
        if (advance)
        begin
            s1_valid_next = rd_en || (accept && (req_type == REQ_FLUSH));
            s1_flush_next = (req_type == REQ_FLUSH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_flush_reg <= s1_flush_next;
        end
    end

    // Zero-length codes produce nothing, so they never enter the queue.
    assign push = s1_valid_reg && !q_status.full
                  && (s1_flush_reg || (rdata_reg.len != '0));
    assign push_job.is_flush = s1_flush_reg;
    assign push_job.code     = rdata_reg;

endmodule

@@ sv/hcbp_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on hcbp_pkg for the job type and depth.
module hcbp_queue
    import hcbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t status
);

    job_t               slots [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/hcbp_back.sv @@
// Back end: appends codes to pending bits, emits a byte per cycle unless stalled.
// Depends on hcbp_pkg; takes jobs from hcbp_queue and drives the output register.
module hcbp_back
    import hcbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  job_t              head_job,
    input  q_status_t         q_status,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last
);

    logic [WORK_W-1:0] work_reg;
    logic [WORK_W-1:0] work_next;
    logic [LEN_W-1:0]  rem_reg;
    logic [LEN_W-1:0]  rem_next;
    logic              busy_reg;
    logic              busy_next;
    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_byte_next;
    logic              last_reg;
    logic              last_next;
    logic              out_free;
    logic              emit;
    logic [WORK_W-1:0] src_w;
    logic [LEN_W-1:0]  src_r;
    logic [LEN_W-1:0]  rem_after;
    logic [LEN_W-1:0]  total;
    logic [LEN_W-1:0]  shamt;
    logic [WORK_W-1:0] new_work;

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = out_free && !busy_reg && !q_status.empty;

    // Pending bits are kept left-aligned, so the new code lands right below them.
    assign total    = {{(LEN_W-CNT_W){1'b0}}, count_reg} + head_job.code.len;
    assign shamt    = LEN_W'(7'd64 - {1'b0, total});
    assign new_work = {pend_reg, {(WORK_W-PEND_W){1'b0}}}
                      | (WORK_W'(head_job.code.value) << shamt);

    always_comb
    begin
        work_next      = work_reg;
        rem_next       = rem_reg;
        busy_next      = busy_reg;
        pend_next      = pend_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        emit           = 1'b0;
        src_w          = work_reg;
        src_r          = rem_reg;
        rem_after      = '0;

        if (out_free)
        begin
            out_valid_next = 1'b0;
            if (busy_reg)
            begin
                emit = 1'b1;
            end
            else if (pop)
            begin
                if (head_job.is_flush)
                begin
                    if (count_reg != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = {pend_reg, 1'b0};
                        last_next      = 1'b1;
                        pend_next      = '0;
                        count_next     = '0;
                    end
                end
                else if (total < LEN_W'(BYTE_W))
                begin
                    pend_next  = new_work[WORK_W-1 -: PEND_W];
                    count_next = total[CNT_W-1:0];
                end
                else
                begin
                    emit  = 1'b1;
                    src_w = new_work;
                    src_r = total;
                end
            end

            if (emit)
            begin
                rem_after      = src_r - LEN_W'(BYTE_W);
                out_valid_next = 1'b1;
                out_byte_next  = src_w[WORK_W-1 -: BYTE_W];
                last_next      = (rem_after < LEN_W'(BYTE_W));
                if (rem_after < LEN_W'(BYTE_W))
                begin
                    busy_next  = 1'b0;
                    pend_next  = src_w[WORK_W-BYTE_W-1 -: PEND_W];
                    count_next = rem_after[CNT_W-1:0];
                end
                else
                begin
                    busy_next = 1'b1;
                    work_next = src_w << BYTE_W;
                    rem_next  = rem_after;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

@@ sv/huffman_code_bit_packer.sv @@
// Huffman code bit packer: a front end with the code table, a job queue and a byte packer.
// Depends on hcbp_pkg, hcbp_front, hcbp_queue and hcbp_back.
//
// The front end takes one input transfer per cycle unless stalled. Table loads are
// written into the single-port code table in the cycle they are accepted, and encode
// lookups read it with a registered read, so a job waits in the front-stage register
// before it enters the four-entry queue. The back end produces one output byte per
// cycle while it has one ready and the output is not stalled. An encode holds the back
// end until its bytes, at most four with 32-bit codes, are out; any other job, including
// a flush, is done when it is popped. The first byte is registered at the edge that takes
// its job from the queue, after the front-stage register and a queue slot.
// Input stalls only while the queue is full and the front stage is holding a job.
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int SYMBOLS      = 256,
    parameter int MAX_CODE_LEN = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [7:0]        symbol,
    input  logic [CODE_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_len,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last
);

    q_status_t q_status;
    logic      push;
    logic      pop;
    job_t      push_job;
    job_t      head_job;

    hcbp_front #(
        .SYMBOLS      (SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .symbol    (symbol),
        .code_bits (code_bits),
        .code_len  (code_len),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    hcbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    hcbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for huffman_code_bit_packer: loads code tables, encodes and flushes,
// and checks every packed output byte against a bit-accurate packer kept in the testbench.
// Depends on hcbp_pkg and the huffman_code_bit_packer RTL.
module tb
    import hcbp_pkg::*;
();

    localparam int SYM_COUNT = 256;
    localparam int MAX_LEN = 32;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } out_rec_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        req_type = REQ_LOAD;
    logic [7:0]        symbol = '0;
    logic [CODE_W-1:0] code_bits = '0;
    logic [LEN_W-1:0]  code_len = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    code_entry_t       code_tab [SYM_COUNT];
    bit                tab_written [SYM_COUNT];
    logic [7:0]        written_syms [$];
    logic [PEND_W-1:0] pend_bits = '0;
    int                pend_cnt = 0;
    out_rec_t          owed_bytes [$];
    out_rec_t          head_rec;
    int                fail_count = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;

    huffman_code_bit_packer #(
        .SYMBOLS      (SYM_COUNT),
        .MAX_CODE_LEN (MAX_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .symbol    (symbol),
        .code_bits (code_bits),
        .code_len  (code_len),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_bytes.size() == 0)
            begin
                $error("unexpected output byte %h, last %b", out_byte, last);
                fail_count++;
            end
            else
            begin
                head_rec = owed_bytes.pop_front();
                if (out_byte !== head_rec.value)
                begin
                    $error("out_byte: expected %h, actual %h", head_rec.value, out_byte);
                    fail_count++;
                end
                if (last !== head_rec.last)
                begin
                    $error("last: expected %b, actual %b", head_rec.last, last);
                    fail_count++;
                end
            end
        end
    end

    task automatic pack_request(input logic [1:0] req, input logic [7:0] sym,
                                input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
        logic [WORK_W-1:0] acc;
        logic [WORK_W-1:0] shifted;
        logic [WORK_W-1:0] masked;
        logic [BYTE_W-1:0] flush_byte;
        code_entry_t       ent;
        out_rec_t          rec;
        int                total;
        case (req)
            REQ_LOAD:
            begin
                if (len <= MAX_LEN)
                begin
                    masked = {{(WORK_W-CODE_W){1'b0}}, bits} & ((64'd1 << len) - 64'd1);
                    ent.value = masked[CODE_W-1:0];
                    ent.len = len;
                    code_tab[sym] = ent;
                    if (!tab_written[sym])
                    begin
                        tab_written[sym] = 1'b1;
                        written_syms.push_back(sym);
                    end
                end
            end
            REQ_ENCODE:
            begin
                ent = code_tab[sym];
                if (ent.len != 0)
                begin
                    acc = {{(WORK_W-PEND_W){1'b0}}, pend_bits};
                    acc = (acc << ent.len) | {{(WORK_W-CODE_W){1'b0}}, ent.value};
                    total = pend_cnt + ent.len;
                    while (total >= BYTE_W)
                    begin
                        shifted = acc >> (total - BYTE_W);
                        rec.value = shifted[BYTE_W-1:0];
                        rec.last = (total - BYTE_W < BYTE_W);
                        owed_bytes.push_back(rec);
                        total -= BYTE_W;
                    end
                    pend_bits = PEND_W'(acc[PEND_W-1:0] & PEND_W'((1 << total) - 1));
                    pend_cnt = total;
                end
            end
            REQ_FLUSH:
            begin
                if (pend_cnt != 0)
                begin
                    flush_byte = {1'b0, pend_bits};
                    rec.value = flush_byte << (BYTE_W - pend_cnt);
                    rec.last = 1'b1;
                    owed_bytes.push_back(rec);
                    pend_bits = '0;
                    pend_cnt = 0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_item(input logic [1:0] req, input logic [7:0] sym,
                             input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        symbol <= sym;
        code_bits <= bits;
        code_len <= len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pack_request(req, sym, bits, len);
    endtask

    task automatic test_long_codes();
        send_item(REQ_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
        send_item(REQ_LOAD, 8'h00, 32'h0000_0000, 6'd32);
        send_item(REQ_LOAD, 8'h01, 32'h0000_0055, 6'd7);
        send_item(REQ_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'd63);
        send_item(REQ_ENCODE, 8'hFF, 32'h0, 6'd0);
        send_item(REQ_ENCODE, 8'h00, 32'h1234_5678, 6'd17);
        send_item(REQ_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        send_item(REQ_LOAD, 8'h80, 32'hA5A5_A5A5, 6'd1);
        send_item(REQ_ENCODE, 8'h80, 32'h0, 6'd0);
        send_item(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    endtask

    task automatic test_ignored_requests();
        send_item(REQ_LOAD, 8'h02, 32'hDEAD_BEEF, 6'd0);
        send_item(REQ_ENCODE, 8'h02, 32'h0, 6'd0);
        send_item(REQ_FLUSH, 8'h02, 32'h0, 6'd0);
        send_item(REQ_LOAD, 8'h03, 32'hCAFE_F00D, 6'd33);
        send_item(REQ_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd63);
        send_item(REQ_ENCODE, 8'h01, 32'h0, 6'd0);
        send_item(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
        send_item(REQ_ENCODE, 8'h80, 32'h0, 6'd0);
        send_item(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
        int          pick;
        int          len_pick;
        logic [1:0]  req;
        logic [7:0]  sym;
        logic [LEN_W-1:0] len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            len_pick = $urandom_range(99);
            sym = 8'($urandom_range(255));
            len = LEN_W'($urandom_range(63));
            if (pick < 15)
            begin
                req = REQ_LOAD;
                if (len_pick < 8)
                    len = '0;
                else if (len_pick < 18)
                    len = LEN_W'($urandom_range(63, 33));
                else if (len_pick < 40)
                    len = LEN_W'($urandom_range(32, 25));
                else
                    len = LEN_W'($urandom_range(24, 1));
            end
            else if (pick < 82)
            begin
                req = REQ_ENCODE;
                sym = written_syms[$urandom_range(written_syms.size() - 1)];
            end
            else if (pick < 95)
                req = REQ_FLUSH;
            else
                req = REQ_UNUSED;
            send_item(req, sym, $urandom, len);
        end
    endtask

    initial
    begin
        send_idle_pct = 8;
        recv_idle_pct = 60;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        test_long_codes();
        test_ignored_requests();
        test_random_traffic(8, 60, 80);
        test_random_traffic(60, 8, 80);
        test_random_traffic(0, 0, 80);
        @(negedge clk);
        in_valid <= 1'b0;
        while (owed_bytes.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
